/* rtl/pvd_pkg.sv */
package pvd_pkg;

	// One transfer on the input side: a single byte of the code stream.
	typedef struct packed {
		logic [7:0] in_byte;
	} pvd_in_t;

	// One transfer on the result side: a finished code.
	typedef struct packed {
		logic signed [31:0] value;
		logic               is_nan;
		logic [2:0]         code_length;
	} pvd_out_t;

	// Lead bytes that escape to four raw big-endian bytes.
	localparam logic [7:0] LEAD_ESC_LO = 8'hdf;
	localparam logic [7:0] LEAD_ESC_HI = 8'he0;

	// Code lengths.
	localparam logic [2:0] LEN_ONE = 3'd1;
	localparam logic [2:0] LEN_TWO = 3'd2;
	localparam logic [2:0] LEN_THREE = 3'd3;
	localparam logic [2:0] LEN_FOUR = 3'd4;
	localparam logic [2:0] LEN_ESC = 3'd5;

	// Raw one-byte value that stands for NaN, and the value given for it.
	localparam logic [31:0] NAN_RAW = 32'hffff_ffe0;
	localparam logic [31:0] NAN_VALUE = 32'h8000_0000;

	// Biases for multi-byte codes, as addends (negative ones in two's complement).
	localparam logic [31:0] BIAS2_POS = 32'h0000_0020;
	localparam logic [31:0] BIAS2_NEG = 32'hffff_ffe1;
	localparam logic [31:0] BIAS3_POS = 32'h0000_2020;
	localparam logic [31:0] BIAS3_NEG = 32'hffff_dfe1;
	localparam logic [31:0] BIAS4_POS = 32'h0020_2020;
	localparam logic [31:0] BIAS4_NEG = 32'hffdf_dfe1;

endpackage

/* rtl/pvd_stream_if.sv */
interface pvd_stream_if #(
	parameter type payload_t = logic [7:0]
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

/* rtl/prefix_varint_decoder.sv */
// Decodes a stream of prefix-length signed variable-length integer codes, one
// byte per transfer, and delivers one 32-bit signed value per completed code
// together with its length in bytes and a NaN flag. The block takes one byte
// every cycle while the result side does not stall; the last byte of a code
// passes the input register and the decode stage, and its result is then
// offered from the result register. The path is an input register, then the
// accumulator shift and a single 32-bit bias adder in front of the result
// register. The input register doubles as a skid stage: while a finished
// result waits on the output side, one byte is still taken into it if empty.
module prefix_varint_decoder
	import pvd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	pvd_stream_if.sink   stream,
	pvd_stream_if.source result
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       advance;

	logic [2:0]  bytes_left_q;
	logic [2:0]  code_len_q;
	logic [31:0] accum_q;

	logic        res_valid_q;
	pvd_out_t    res_q;

	logic [2:0]  bytes_left_d;
	logic [2:0]  code_len_d;
	logic [31:0] accum_d;
	logic        finish;
	logic [31:0] bias;
	logic        nan_hit;
	logic [31:0] value_d;

	// The decode stage moves on unless a result is held back by the sink.
	assign advance = !res_valid_q || result.ready;
	assign stream.ready = !valid_s1 || advance;

	// Input register: one byte waiting for the decode stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stream.ready) begin
			valid_s1 <= stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (stream.ready && stream.valid) begin
			byte_s1 <= stream.payload.in_byte;
		end
	end

	// Next state of the code being read.
	always_comb begin
		bytes_left_d = bytes_left_q;
		code_len_d = code_len_q;
		accum_d = accum_q;
		finish = 1'b0;
		if (bytes_left_q == 3'd0) begin
			if (byte_s1 == LEAD_ESC_LO || byte_s1 == LEAD_ESC_HI) begin
				code_len_d = LEN_ESC;
				bytes_left_d = LEN_FOUR;
				accum_d = '0;
			end else begin
				code_len_d = {1'b0, byte_s1[7:6]} + 3'd1;
				accum_d = {{26{byte_s1[5]}}, byte_s1[5:0]};
				if (byte_s1[7:6] == 2'b00) begin
					finish = 1'b1;
				end else begin
					bytes_left_d = {1'b0, byte_s1[7:6]};
				end
			end
		end else begin
			accum_d = {accum_q[23:0], byte_s1};
			bytes_left_d = bytes_left_q - 3'd1;
			finish = (bytes_left_q == 3'd1);
		end
	end

	// Bias selection by length and sign, then the NaN substitution.
	always_comb begin
		bias = '0;
		nan_hit = 1'b0;
		unique case (code_len_d)
			LEN_ONE: nan_hit = (accum_d == NAN_RAW);
			LEN_TWO: bias = accum_d[31] ? BIAS2_NEG : BIAS2_POS;
			LEN_THREE: bias = accum_d[31] ? BIAS3_NEG : BIAS3_POS;
			LEN_FOUR: bias = accum_d[31] ? BIAS4_NEG : BIAS4_POS;
			default: bias = '0;
		endcase
		value_d = nan_hit ? NAN_VALUE : accum_d + bias;
	end

	// Code state, updated when a byte leaves the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_left_q <= '0;
			code_len_q <= '0;
			accum_q <= '0;
		end else if (valid_s1 && advance) begin
			bytes_left_q <= finish ? 3'd0 : bytes_left_d;
			code_len_q <= code_len_d;
			accum_q <= accum_d;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= valid_s1 && finish;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && finish) begin
			res_q.value <= value_d;
			res_q.is_nan <= nan_hit;
			res_q.code_length <= code_len_d;
		end
	end

	assign result.valid = res_valid_q;
	assign result.payload = res_q;

	// A delivered result always carries a length from one to five.
	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> (res_q.code_length != 3'd0 && res_q.code_length <= LEN_ESC))
		else $error("result length out of range");

	// NaN only comes from a one-byte code and carries the fixed value.
	a_nan_form: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.is_nan) |->
			(res_q.code_length == LEN_ONE && res_q.value == NAN_VALUE))
		else $error("malformed NaN result");

	// The byte counter never exceeds the escape's four trailing bytes.
	a_left_bound: assert property (@(posedge clk) disable iff (!arst_n)
		bytes_left_q <= LEN_FOUR)
		else $error("byte counter out of range");

	// An escape lead byte arms four trailing bytes and gives no result.
	a_escape: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance && bytes_left_q == 3'd0 &&
			(byte_s1 == LEAD_ESC_LO || byte_s1 == LEAD_ESC_HI)) |=>
			(bytes_left_q == LEN_FOUR && code_len_q == LEN_ESC && !res_valid_q))
		else $error("escape lead handled wrongly");

	// A stalled result stays in place.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !result.ready) |=> (res_valid_q && $stable(res_q)))
		else $error("stalled result changed");

endmodule
